FILE: sv/fssa_pkg.sv
`timescale 1ns / 1ps
// fssa_pkg: constants, codes and sizes shared by the slot allocator core and its checker
// depends on nothing

package fssa_pkg;

	localparam int unsigned FREE_STACK_DEPTH = 256;
	localparam longint unsigned REGION_BYTES = 64'd16777216;

	localparam int unsigned STACK_IDX_W = $clog2(FREE_STACK_DEPTH);
	localparam int unsigned STACK_DEPTH_W = $clog2(FREE_STACK_DEPTH + 1);

	localparam int unsigned ADDR_W = 32;
	localparam int unsigned ELEM_W = 16;
	localparam int unsigned STAMP_SIZE_W = 21;
	localparam int unsigned CFG_DATA_W = 21;
	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned LIVE_W = 20;
	localparam int unsigned STAMP_CNT_W = 16;
	localparam int unsigned IPS_W = 17;
	localparam int unsigned DIV_CNT_W = $clog2(STAMP_SIZE_W + 1);

	localparam logic [LIVE_W-1:0] LIVE_MAX = '1;
	localparam logic [STAMP_CNT_W-1:0] STAMP_MAX = '1;
	localparam logic [IPS_W-1:0] IPS_MAX = '1;

	localparam logic [ELEM_W-1:0] ELEM_SIZE_RESET = ELEM_W'(1);
	localparam logic [STAMP_SIZE_W-1:0] STAMP_SIZE_RESET = STAMP_SIZE_W'(4096);
	localparam logic [IPS_W-1:0] IPS_RESET = IPS_W'(4096);

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_ELEM_SIZE = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_STAMP_SIZE = 1'b1;

	// opcodes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE = 1'b1;

	// status codes
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_STACK_FULL = 2'd1;
	localparam logic [1:0] ST_EXHAUSTED = 2'd2;
	localparam logic [1:0] ST_NONE_LIVE = 2'd3;

endpackage

FILE: sv/fixed_size_slot_allocator_core.sv
`timescale 1ns / 1ps
// fixed_size_slot_allocator_core: fixed-size slot allocator with a lifo free stack in memory
// depends on fssa_pkg
//
// a result is registered in the execute stage, then in the output register
// the input takes no new item until the current one finishes, as the free stack read must return
//   before the item can finish and the next item may read the stack
// a configuration write stalls the input while items_per_stamp is divided out,
//   and not at all when the element size is zero
// reset: counters cleared, stamp count one, registers at their reset values; the free stack
//   memory is not cleared, only entries below the depth are ever used

module fixed_size_slot_allocator_core import fssa_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,

	input  logic                     cfg_write,
	input  logic [CFG_INDEX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,

	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     opcode,
	input  logic [ADDR_W-1:0]        free_address,

	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [ADDR_W-1:0]        alloc_address,
	output logic [LIVE_W-1:0]        live_elements,
	output logic [STAMP_CNT_W-1:0]   stamps_used,
	output logic [1:0]               status
);

	localparam logic [ADDR_W:0] REGION_LIMIT = (ADDR_W + 1)'(REGION_BYTES);

	// configuration registers and the derived slot count
	logic [ELEM_W-1:0]        elem_q;
	logic [STAMP_SIZE_W-1:0]  stamp_size_q;
	logic [IPS_W-1:0]         ips_q;

	// allocator state
	logic [STACK_DEPTH_W-1:0] depth_q;
	logic [ADDR_W-1:0]        bump_q;
	logic [IPS_W-1:0]         slot_q;
	logic [STAMP_CNT_W-1:0]   stamp_cnt_q;
	logic [LIVE_W-1:0]        live_q;

	// free stack memory
	logic [ADDR_W-1:0]        stack_mem [FREE_STACK_DEPTH];
	logic [ADDR_W-1:0]        stack_rdata_s1;

	// execute stage: the item waiting for its stack read
	logic                     valid_s1;
	logic                     op_s1;
	logic [ADDR_W-1:0]        faddr_s1;

	// divider for items_per_stamp = stamp_size / elem_size
	logic                     div_busy_q;
	logic [DIV_CNT_W-1:0]     div_cnt_q;
	logic [STAMP_SIZE_W-1:0]  div_quo_q;
	logic [ELEM_W:0]          div_rem_q;
	logic [ELEM_W-1:0]        div_dsr_q;

	logic                     in_accept;
	logic                     finish;
	logic [STACK_DEPTH_W-1:0] depth_m1;

	assign in_stall  = div_busy_q | valid_s1;
	assign in_accept = in_valid & ~in_stall;
	// the item finishes once the output register is free or being emptied
	assign finish    = valid_s1 & (~out_valid | ~out_stall);
	assign depth_m1  = depth_q - STACK_DEPTH_W'(1);

	// ---------------------------------------------------------------------
	// configuration write and iterative divide
	// ---------------------------------------------------------------------
	logic [ELEM_W-1:0]       new_elem;
	logic [STAMP_SIZE_W-1:0] new_stamp;
	logic                    cfg_hit;
	logic [ELEM_W:0]         div_trial;
	logic                    div_bit;
	logic [ELEM_W:0]         div_rem_nxt;
	logic [STAMP_SIZE_W-1:0] div_quo_nxt;
	logic [IPS_W-1:0]        div_result;

	always_comb begin
		new_elem  = elem_q;
		new_stamp = stamp_size_q;
		cfg_hit   = 1'b0;
		if (cfg_write) begin
			unique case (cfg_index)
				CFG_ELEM_SIZE: begin
					new_elem = cfg_data[ELEM_W-1:0];
					cfg_hit  = 1'b1;
				end
				CFG_STAMP_SIZE: begin
					new_stamp = cfg_data[STAMP_SIZE_W-1:0];
					cfg_hit   = 1'b1;
				end
				default: begin
					cfg_hit = 1'b0;
				end
			endcase
		end
	end

	// one restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		div_trial = {div_rem_q[ELEM_W-1:0], div_quo_q[STAMP_SIZE_W-1]};
		div_bit   = (div_trial >= {1'b0, div_dsr_q});
		div_rem_nxt = div_bit ? (div_trial - {1'b0, div_dsr_q}) : div_trial;
		div_quo_nxt = {div_quo_q[STAMP_SIZE_W-2:0], div_bit};
		// zero quotient rounds up to one slot, large ones saturate
		if (div_quo_nxt == '0) begin
			div_result = IPS_W'(1);
		end else if (div_quo_nxt > STAMP_SIZE_W'(IPS_MAX)) begin
			div_result = IPS_MAX;
		end else begin
			div_result = div_quo_nxt[IPS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_q       <= ELEM_SIZE_RESET;
			stamp_size_q <= STAMP_SIZE_RESET;
			ips_q        <= IPS_RESET;
			div_busy_q   <= 1'b0;
			div_cnt_q    <= '0;
		end else if (cfg_hit) begin
			elem_q       <= new_elem;
			stamp_size_q <= new_stamp;
			if (new_elem == '0) begin
				// null elements: one slot per stamp, no divide needed
				ips_q      <= IPS_W'(1);
				div_busy_q <= 1'b0;
			end else begin
				div_busy_q <= 1'b1;
				div_cnt_q  <= DIV_CNT_W'(STAMP_SIZE_W);
			end
		end else if (div_busy_q) begin
			div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
			if (div_cnt_q == DIV_CNT_W'(1)) begin
				div_busy_q <= 1'b0;
				ips_q      <= div_result;
			end
		end
	end

	// divider datapath
	always_ff @(posedge clk) begin
		if (cfg_hit) begin
			div_quo_q <= new_stamp;
			div_rem_q <= '0;
			div_dsr_q <= new_elem;
		end else if (div_busy_q) begin
			div_quo_q <= div_quo_nxt;
			div_rem_q <= div_rem_nxt;
		end
	end

	// ---------------------------------------------------------------------
	// accept stage: register the item and start the pop read
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (finish) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_s1    <= opcode;
			faddr_s1 <= free_address;
		end
	end

	// ---------------------------------------------------------------------
	// execute stage: work out the step from the registered item and read data
	// ---------------------------------------------------------------------
	logic [STACK_DEPTH_W-1:0] depth_nxt;
	logic [ADDR_W-1:0]        bump_nxt;
	logic [IPS_W-1:0]         slot_nxt;
	logic [STAMP_CNT_W-1:0]   stamp_nxt;
	logic [LIVE_W-1:0]        live_nxt;
	logic [ADDR_W-1:0]        addr_res;
	logic [1:0]               status_res;
	logic                     push;
	logic [ADDR_W:0]          bump_end;
	logic [IPS_W-1:0]         slot_inc;
	logic [LIVE_W-1:0]        live_inc;

	assign bump_end = {1'b0, bump_q} + {{(ADDR_W + 1 - ELEM_W){1'b0}}, elem_q};
	assign slot_inc = slot_q + IPS_W'(1);
	assign live_inc = (live_q < LIVE_MAX) ? (live_q + LIVE_W'(1)) : live_q;

	always_comb begin
		depth_nxt  = depth_q;
		bump_nxt   = bump_q;
		slot_nxt   = slot_q;
		stamp_nxt  = stamp_cnt_q;
		live_nxt   = live_q;
		addr_res   = '0;
		status_res = ST_OK;
		push       = 1'b0;
		if (op_s1 == OP_ALLOC) begin
			if (elem_q == '0) begin
				live_nxt = live_inc;
			end else if (depth_q != '0) begin
				// pop the most recently freed address
				depth_nxt = depth_m1;
				addr_res  = stack_rdata_s1;
				live_nxt  = live_inc;
			end else if (bump_end > REGION_LIMIT) begin
				status_res = ST_EXHAUSTED;
			end else begin
				addr_res = bump_q;
				bump_nxt = bump_end[ADDR_W-1:0];
				live_nxt = live_inc;
				// close the stamp after its last slot, or when the slot index wraps
				if (slot_inc >= ips_q || slot_inc == '0) begin
					slot_nxt = '0;
					if (stamp_cnt_q < STAMP_MAX) begin
						stamp_nxt = stamp_cnt_q + STAMP_CNT_W'(1);
					end
				end else begin
					slot_nxt = slot_inc;
				end
			end
		end else begin
			if (live_q == '0) begin
				status_res = ST_NONE_LIVE;
			end else if (elem_q == '0) begin
				live_nxt = live_q - LIVE_W'(1);
			end else if (depth_q >= STACK_DEPTH_W'(FREE_STACK_DEPTH)) begin
				status_res = ST_STACK_FULL;
			end else begin
				push      = 1'b1;
				depth_nxt = depth_q + STACK_DEPTH_W'(1);
				live_nxt  = live_q - LIVE_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q     <= '0;
			bump_q      <= '0;
			slot_q      <= '0;
			stamp_cnt_q <= STAMP_CNT_W'(1);
			live_q      <= '0;
		end else if (finish) begin
			depth_q     <= depth_nxt;
			bump_q      <= bump_nxt;
			slot_q      <= slot_nxt;
			stamp_cnt_q <= stamp_nxt;
			live_q      <= live_nxt;
		end
	end

	// free stack: push at the current depth, read the top on accept
	always_ff @(posedge clk) begin
		if (finish && push) begin
			stack_mem[depth_q[STACK_IDX_W-1:0]] <= faddr_s1;
		end
		if (in_accept) begin
			stack_rdata_s1 <= stack_mem[depth_m1[STACK_IDX_W-1:0]];
		end
	end

	// ---------------------------------------------------------------------
	// output register
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (finish) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			alloc_address <= addr_res;
			live_elements <= live_nxt;
			stamps_used   <= stamp_nxt;
			status        <= status_res;
		end
	end

endmodule

FILE: sv/fssa_checker.sv
`timescale 1ns / 1ps
// fssa_checker: port-level assertions for the slot allocator core, with its bind
// depends on fssa_pkg and fixed_size_slot_allocator_core

module fssa_checker import fssa_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_stall,
	input  logic                   out_valid,
	input  logic                   out_stall,
	input  logic [ADDR_W-1:0]      alloc_address,
	input  logic [LIVE_W-1:0]      live_elements,
	input  logic [STAMP_CNT_W-1:0] stamps_used,
	input  logic [1:0]             status
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(alloc_address)
			&& $stable(live_elements) && $stable(stamps_used) && $stable(status))
		else $error("stalled result changed");

	// one item at a time: the input stalls right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while an item is in flight");

	// an error status hands out no address; frees also give zero, which this does not check
	a_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> alloc_address == '0)
		else $error("address given with an error status");

	// a free with none live reports zero live elements
	a_none_live: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_NONE_LIVE) |-> live_elements == '0)
		else $error("none-live status with live elements");

	// the stamp count never drops below one
	a_stamp_min: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> stamps_used != '0)
		else $error("stamp count is zero");

endmodule

bind fixed_size_slot_allocator_core fssa_checker u_fssa_checker (.*);
